### src/sextant_dot_canvas_store_top_assert.svh
// assertion macros for the sextant dot canvas store checker
// depends on nothing; included by sdcs_checker.sv
`ifndef SEXTANT_DOT_CANVAS_STORE_TOP_ASSERT_SVH
`define SEXTANT_DOT_CANVAS_STORE_TOP_ASSERT_SVH

// same-cycle implication
`define SDCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdcs check failed");

// next-cycle implication
`define SDCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdcs check failed");

`endif

### src/sdcs_pkg.sv
// shared types, constants and glyph lookup for the sextant dot canvas store
// depends on nothing
`timescale 1ns / 1ps

package sdcs_pkg;

   localparam int KindW     = 2;
   localparam int CoordW    = 8;
   localparam int CodeW     = 21;
   localparam int MaskW     = 6;
   localparam int ColsW     = 8;
   localparam int RowsW     = 7;
   localparam int CsrIdxW   = 1;
   localparam int CsrDataW  = 8;
   localparam int QueueDepth = 4;

   typedef enum logic [KindW-1:0] {
      KIND_DOT   = 2'd0,
      KIND_CHAR  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   localparam logic [CsrIdxW-1:0] CSR_COLS = 1'd0;
   localparam logic [CsrIdxW-1:0] CSR_ROWS = 1'd1;

   localparam logic [ColsW-1:0] ColsReset = 8'd128;
   localparam logic [RowsW-1:0] RowsReset = 7'd64;

   localparam logic [CodeW-1:0] GlyphBlank = 21'h00020;
   localparam logic [CodeW-1:0] GlyphLeft  = 21'h0258C;
   localparam logic [CodeW-1:0] GlyphRight = 21'h02590;
   localparam logic [CodeW-1:0] GlyphFull  = 21'h02588;
   localparam logic [CodeW-1:0] GlyphBase  = 21'h1FB00;

   localparam logic [MaskW-1:0] MaskLeft  = 6'd21;
   localparam logic [MaskW-1:0] MaskRight = 6'd42;
   localparam logic [MaskW-1:0] MaskFull  = 6'd63;

   typedef struct packed {
      kind_type         kind;
      logic [MaskW-1:0] dot_mask;
      logic             dot_value;
      logic [CodeW-1:0] char_code;
      logic             in_range;
   } cmd_type;

   function automatic logic [CodeW-1:0] glyph_code(input logic [MaskW-1:0] m);
      logic [CodeW-1:0] ext;
      ext = CodeW'(m);
      if (m == '0) begin
         return GlyphBlank;
      end else if (m == MaskLeft) begin
         return GlyphLeft;
      end else if (m == MaskRight) begin
         return GlyphRight;
      end else if (m == MaskFull) begin
         return GlyphFull;
      end else if (m < MaskLeft) begin
         return GlyphBase + ext - 21'd1;
      end else if (m < MaskRight) begin
         return GlyphBase + ext - 21'd2;
      end else begin
         return GlyphBase + ext - 21'd3;
      end
   endfunction

endpackage

### src/sdcs_ram.sv
// generic single write port, single registered read port ram
// depends on nothing
`timescale 1ns / 1ps

module sdcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/sdcs_queue.sv
// short command queue between the front and back parts
// depends on sdcs_pkg for the queue depth
`timescale 1ns / 1ps

module sdcs_queue
   import sdcs_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             full,
   output logic             empty
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

   logic [WIDTH-1:0] data_ff [QueueDepth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FullCnt);
   assign empty     = (count_ff == '0);
   assign head_data = data_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/sdcs_front.sv
// front part: size registers, bounds checks and cell address mapping
// depends on sdcs_pkg for command types and field widths
`timescale 1ns / 1ps

module sdcs_front
   import sdcs_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64,
   localparam int Cells = MAX_COLS * MAX_ROWS,
   localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic [KindW-1:0]    req_kind,
   input  logic [CoordW-1:0]   req_x,
   input  logic [CoordW-1:0]   req_y,
   input  logic                req_dot_value,
   input  logic [CodeW-1:0]    req_char_code,
   output cmd_type             cmd,
   output logic [AddrW-1:0]    cmd_addr
);

   localparam logic [10:0] MaxColsW = 11'(MAX_COLS);
   localparam logic [10:0] MaxRowsW = 11'(MAX_ROWS);

   logic [ColsW-1:0] cols_ff;
   logic [RowsW-1:0] rows_ff;
   logic [10:0]      eff_cols, eff_rows;
   logic [11:0]      dot_x_lim, dot_y_lim;
   logic [16:0]      y_prod;
   logic [7:0]       y_div3;
   logic [7:0]       y_times3;
   logic [1:0]       y_mod3;
   logic [2:0]       bit_pos;
   logic [7:0]       cell_x, cell_y;
   logic             dot_ok, cell_ok;
   kind_type         kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= ColsReset;
         rows_ff <= RowsReset;
      end else if (csr_write) begin
         if (csr_index == CSR_COLS) begin
            cols_ff <= csr_wdata[ColsW-1:0];
         end else if (csr_index == CSR_ROWS) begin
            rows_ff <= csr_wdata[RowsW-1:0];
         end
      end
   end

   assign kind     = kind_type'(req_kind);
   assign eff_cols = (11'(cols_ff) > MaxColsW) ? MaxColsW : 11'(cols_ff);
   assign eff_rows = (11'(rows_ff) > MaxRowsW) ? MaxRowsW : 11'(rows_ff);

   // y / 3 by reciprocal, exact for 8-bit y
   assign y_prod    = 17'(req_y) * 17'd171;
   assign y_div3    = y_prod[16:9];
   assign y_times3  = 8'(y_div3 + {y_div3[6:0], 1'b0});
   assign y_mod3    = 2'(req_y - y_times3);
   assign bit_pos   = {y_mod3, 1'b0} + 3'(req_x[0]);

   assign dot_x_lim = {eff_cols, 1'b0};
   assign dot_y_lim = 12'(eff_rows) + {eff_rows, 1'b0};
   assign dot_ok    = (12'(req_x) < dot_x_lim) && (12'(req_y) < dot_y_lim);
   assign cell_ok   = (11'(req_x) < eff_cols) && (11'(req_y) < eff_rows);

   always_comb begin
      cell_x = req_x;
      cell_y = req_y;
      if (kind == KIND_DOT) begin
         cell_x = {1'b0, req_x[7:1]};
         cell_y = y_div3;
      end
   end

   assign cmd_addr = AddrW'(32'(cell_y) * 32'(MAX_COLS) + 32'(cell_x));

   assign cmd.kind      = kind;
   assign cmd.dot_mask  = MaskW'(1) << bit_pos;
   assign cmd.dot_value = req_dot_value;
   assign cmd.char_code = req_char_code;
   assign cmd.in_range  = (kind == KIND_DOT) ? dot_ok : cell_ok;

endmodule

### src/sdcs_back.sv
// back part: cell store, wipe sweep, dot and char writes, read response register
// depends on sdcs_pkg and sdcs_ram
`timescale 1ns / 1ps

module sdcs_back
   import sdcs_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64,
   localparam int Cells = MAX_COLS * MAX_ROWS,
   localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          q_cmd,
   input  logic [AddrW-1:0] q_addr,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             init_busy,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [CodeW-1:0] rsp_symbol_code,
   output logic             rsp_out_of_range
);

   localparam logic [AddrW-1:0] LastAddr = AddrW'(Cells - 1);

   typedef enum logic [2:0] {
      ST_WIPE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_EXEC  = 3'b100
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic             init_ff, init_in;
   logic [AddrW-1:0] wipe_addr_ff, wipe_addr_in;
   cmd_type          cur_ff, cur_in;
   logic [AddrW-1:0] cur_addr_ff, cur_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CodeW-1:0] sym_ff, sym_in;
   logic             oor_ff, oor_in;

   logic             rd_en, mask_we, ovl_we;
   logic [AddrW-1:0] wr_addr;
   logic [MaskW-1:0] mask_wdata, mask_rd;
   logic [CodeW-1:0] ovl_wdata, ovl_rd;

   sdcs_ram #(.WIDTH(MaskW), .DEPTH(Cells)) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_we),
      .wr_addr (wr_addr),
      .wr_data (mask_wdata),
      .rd_en   (rd_en),
      .rd_addr (q_addr),
      .rd_data (mask_rd)
   );

   sdcs_ram #(.WIDTH(CodeW), .DEPTH(Cells)) u_overlay_ram (
      .clock   (clock),
      .wr_en   (ovl_we),
      .wr_addr (wr_addr),
      .wr_data (ovl_wdata),
      .rd_en   (rd_en),
      .rd_addr (q_addr),
      .rd_data (ovl_rd)
   );

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      wipe_addr_in = wipe_addr_ff;
      cur_in       = cur_ff;
      cur_addr_in  = cur_addr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      sym_in       = sym_ff;
      oor_in       = oor_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      mask_we      = 1'b0;
      ovl_we       = 1'b0;
      wr_addr      = cur_addr_ff;
      mask_wdata   = cur_ff.dot_value ? (mask_rd | cur_ff.dot_mask)
                                      : (mask_rd & ~cur_ff.dot_mask);
      ovl_wdata    = cur_ff.char_code;
      case (state_ff)
         ST_WIPE: begin
            mask_we    = 1'b1;
            ovl_we     = 1'b1;
            wr_addr    = wipe_addr_ff;
            mask_wdata = '0;
            ovl_wdata  = '0;
            if (wipe_addr_ff == LastAddr) begin
               state_in = ST_ISSUE;
               init_in  = 1'b0;
            end else begin
               wipe_addr_in = wipe_addr_ff + 1'b1;
            end
         end
         ST_ISSUE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               cur_in      = q_cmd;
               cur_addr_in = q_addr;
               if (q_cmd.kind == KIND_CLEAR) begin
                  state_in     = ST_WIPE;
                  wipe_addr_in = '0;
               end else begin
                  rd_en    = 1'b1;
                  state_in = ST_EXEC;
               end
            end
         end
         ST_EXEC: begin
            case (cur_ff.kind)
               KIND_DOT: begin
                  mask_we  = cur_ff.in_range;
                  state_in = ST_ISSUE;
               end
               KIND_CHAR: begin
                  ovl_we   = cur_ff.in_range;
                  state_in = ST_ISSUE;
               end
               KIND_READ: begin
                  if (!rsp_valid_ff || !rsp_stall) begin
                     rsp_valid_in = 1'b1;
                     oor_in       = !cur_ff.in_range;
                     if (!cur_ff.in_range) begin
                        sym_in = '0;
                     end else if (ovl_rd != '0) begin
                        sym_in = ovl_rd;
                     end else begin
                        sym_in = glyph_code(mask_rd);
                     end
                     state_in = ST_ISSUE;
                  end
               end
               default: begin
                  state_in = ST_ISSUE;
               end
            endcase
         end
         default: begin
            state_in = ST_ISSUE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         init_ff      <= 1'b1;
         wipe_addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         wipe_addr_ff <= wipe_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      cur_addr_ff <= cur_addr_in;
      sym_ff      <= sym_in;
      oor_ff      <= oor_in;
   end

   assign init_busy        = init_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_symbol_code  = sym_ff;
   assign rsp_out_of_range = oor_ff;

endmodule

### src/sextant_dot_canvas_store_top.sv
// top level of the sextant dot canvas store
// depends on sdcs_pkg, sdcs_front, sdcs_queue and sdcs_back
`timescale 1ns / 1ps

// character-cell frame buffer, each cell a 2x3 dot mask plus an override code
// req channel: one item per command (set dot, set char, clear all, read cell)
// rsp channel: one item per read cell command, in command order
// csr port: csr_write with csr_index 0 sets cols, 1 sets rows; write while idle
// the front checks bounds and maps the cell in the accept cycle and pushes the
// command into a four-entry queue; items enter back to back until it fills,
// seven from empty while the back runs, four while the back sweeps
// the back takes a dot, char or read command through an issue state, with a
// cell store read, and an exec state, with the write of the updated dot mask
// or override or the load of the response register; a new command is popped
// only in the issue state; a read cell item's rsp_valid is loaded in exec
// clear all sweeps all MAX_COLS * MAX_ROWS cells of both stores one cell a
// cycle, while the queue keeps taking items
// after reset the same sweep runs with req_stall held high; cols and rows
// return to 128 and 64
// while rsp_stall is high the response holds, and a following read waits in
// the back, after which the queue fills and raises req_stall
module sextant_dot_canvas_store_top
   import sdcs_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KindW-1:0]    req_kind,
   input  logic [CoordW-1:0]   req_x,
   input  logic [CoordW-1:0]   req_y,
   input  logic                req_dot_value,
   input  logic [CodeW-1:0]    req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CodeW-1:0]    rsp_symbol_code,
   output logic                rsp_out_of_range
);

   localparam int Cells  = MAX_COLS * MAX_ROWS;
   localparam int AddrW  = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int EntryW = $bits(cmd_type) + AddrW;

   cmd_type           front_cmd, q_cmd;
   logic [AddrW-1:0]  front_addr, q_addr;
   logic [EntryW-1:0] q_head;
   logic              q_full, q_empty, q_pop, init_busy, push;

   sdcs_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_kind      (req_kind),
      .req_x         (req_x),
      .req_y         (req_y),
      .req_dot_value (req_dot_value),
      .req_char_code (req_char_code),
      .cmd           (front_cmd),
      .cmd_addr      (front_addr)
   );

   assign req_stall = q_full || init_busy;
   assign push      = req_valid && !req_stall;

   sdcs_queue #(.WIDTH(EntryW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_cmd, front_addr}),
      .pop       (q_pop),
      .head_data (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   assign q_cmd  = cmd_type'(q_head[EntryW-1:AddrW]);
   assign q_addr = q_head[AddrW-1:0];

   sdcs_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_cmd            (q_cmd),
      .q_addr           (q_addr),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .init_busy        (init_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_symbol_code  (rsp_symbol_code),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

### src/sdcs_checker.sv
// port-level checks for the sextant dot canvas store, bound to the top level
// depends on sdcs_pkg and sextant_dot_canvas_store_top_assert.svh
`timescale 1ns / 1ps
`include "sextant_dot_canvas_store_top_assert.svh"

module sdcs_props
   import sdcs_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [CodeW-1:0] rsp_symbol_code,
   input logic             rsp_out_of_range
);

   // a stalled item stays offered
   `SDCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a stalled item keeps its symbol
   `SDCS_ASSERT_NEXT(a_rsp_sym, clock, reset, rsp_valid && rsp_stall, $stable(rsp_symbol_code))

   // an out of range read carries no symbol
   `SDCS_ASSERT_NOW(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range,
      rsp_symbol_code == '0)

   // the store sweep after reset holds off new items
   `SDCS_ASSERT_NOW(a_init_stall, clock, reset, $past(reset), req_stall)

   // no item is shown before any command could reach the back
   `SDCS_ASSERT_NOW(a_no_early_rsp, clock, reset, $past(reset) || $past(reset, 2), !rsp_valid)

endmodule

bind sextant_dot_canvas_store_top sdcs_props u_props (.*);

### test/sdcs_checker.sv
// checker for the sextant dot canvas store: watches csr, req and rsp, keeps its own
// copy of the cell store and geometry, and compares each read result in order
// depends on sdcs_pkg
`timescale 1ns / 1ps

module sdcs_checker
   import sdcs_pkg::*;
#(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [KindW-1:0]    req_kind,
   input  logic [CoordW-1:0]   req_x,
   input  logic [CoordW-1:0]   req_y,
   input  logic                req_dot_value,
   input  logic [CodeW-1:0]    req_char_code,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [CodeW-1:0]    rsp_symbol_code,
   input  logic                rsp_out_of_range,
   output int                  errors,
   output int                  outstanding,
   output int                  reads_checked
);

   localparam int Cells = MAX_COLS * MAX_ROWS;

   typedef struct {
      logic [CodeW-1:0] symbol_code;
      logic             out_of_range;
   } cell_view_type;

   logic [MaskW-1:0] dot_mem [Cells];
   logic [CodeW-1:0] overlay_mem [Cells];
   logic [ColsW-1:0] cols_now;
   logic [RowsW-1:0] rows_now;
   cell_view_type    shown_q [$];
   int               fail_count = 0;
   int               waiting = 0;
   int               compared = 0;

   assign errors = fail_count;
   assign outstanding = waiting;
   assign reads_checked = compared;

   // glyphs are numbered upward from the base, skipping the half and full blocks
   function automatic logic [CodeW-1:0] sextant_glyph(input logic [MaskW-1:0] m);
      int unsigned skipped;
      case (m)
         '0:        return GlyphBlank;
         MaskLeft:  return GlyphLeft;
         MaskRight: return GlyphRight;
         MaskFull:  return GlyphFull;
         default: begin
            skipped = 1 + int'(m > MaskLeft) + int'(m > MaskRight);
            return GlyphBase + CodeW'(m) - CodeW'(skipped);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      int unsigned   ec;
      int unsigned   er;
      int unsigned   cell_idx;
      int unsigned   bitpos;
      cell_view_type want;
      if (reset) begin
         for (int i = 0; i < Cells; i++) begin
            dot_mem[i] = '0;
            overlay_mem[i] = '0;
         end
         cols_now = ColsReset;
         rows_now = RowsReset;
         shown_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (shown_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected read result: symbol_code %h out_of_range %b",
                        $time, rsp_symbol_code, rsp_out_of_range);
            end else begin
               want = shown_q.pop_front();
               compared++;
               if (rsp_symbol_code !== want.symbol_code) begin
                  fail_count++;
                  $display("%0t: symbol_code expected %h got %h",
                           $time, want.symbol_code, rsp_symbol_code);
               end
               if (rsp_out_of_range !== want.out_of_range) begin
                  fail_count++;
                  $display("%0t: out_of_range expected %b got %b",
                           $time, want.out_of_range, rsp_out_of_range);
               end
            end
         end
         if (req_valid && !req_stall) begin
            ec = (cols_now > MAX_COLS) ? MAX_COLS : cols_now;
            er = (rows_now > MAX_ROWS) ? MAX_ROWS : rows_now;
            case (kind_type'(req_kind))
               KIND_DOT: begin
                  if (req_x < 2 * ec && req_y < 3 * er) begin
                     cell_idx = (req_y / 3) * MAX_COLS + req_x / 2;
                     bitpos = (req_y % 3) * 2 + req_x % 2;
                     dot_mem[cell_idx][bitpos] = req_dot_value;
                  end
               end
               KIND_CHAR: begin
                  if (req_x < ec && req_y < er) begin
                     overlay_mem[req_y * MAX_COLS + req_x] = req_char_code;
                  end
               end
               KIND_CLEAR: begin
                  for (int i = 0; i < Cells; i++) begin
                     dot_mem[i] = '0;
                     overlay_mem[i] = '0;
                  end
               end
               KIND_READ: begin
                  if (req_x < ec && req_y < er) begin
                     cell_idx = req_y * MAX_COLS + req_x;
                     want.symbol_code = (overlay_mem[cell_idx] != '0)
                                        ? overlay_mem[cell_idx]
                                        : sextant_glyph(dot_mem[cell_idx]);
                     want.out_of_range = 1'b0;
                  end else begin
                     want.symbol_code = '0;
                     want.out_of_range = 1'b1;
                  end
                  shown_q.push_back(want);
               end
               default: begin
               end
            endcase
         end
         // a size write applies to items accepted after it
         if (csr_write) begin
            if (csr_index == CSR_COLS) begin
               cols_now = csr_wdata[ColsW-1:0];
            end else if (csr_index == CSR_ROWS) begin
               rows_now = csr_wdata[RowsW-1:0];
            end
         end
      end
      waiting = shown_q.size();
   end

endmodule

### test/testbench.sv
// testbench top for the sextant dot canvas store: clock, reset, csr writes and
// directed and random dot, char, clear and read items over several cell geometries
// depends on sdcs_pkg, sextant_dot_canvas_store_top and sdcs_checker
`timescale 1ns / 1ps

module testbench;
   import sdcs_pkg::*;

   localparam int MaxCols = 128;
   localparam int MaxRows = 64;
   localparam int HalfPeriod = 5;
   localparam int SweepCycles = MaxCols * MaxRows;
   localparam int ChokeCycles = 400;
   localparam int CycleLimit = 1_000_000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_write = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = CSR_COLS;
   logic [CsrDataW-1:0] csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic [KindW-1:0]    req_kind = KIND_READ;
   logic [CoordW-1:0]   req_x = '0;
   logic [CoordW-1:0]   req_y = '0;
   logic                req_dot_value = 1'b0;
   logic [CodeW-1:0]    req_char_code = '0;
   logic                rsp_stall = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic [CodeW-1:0]    rsp_symbol_code;
   logic                rsp_out_of_range;

   int          errors;
   int          outstanding;
   int          reads_checked;
   int unsigned cycles = 0;
   bit          calm = 1'b0;
   bit          choke_pending = 1'b0;
   bit          clear_since_drain = 1'b0;
   int          clears_left = 8;
   int          geometries = 1;
   int unsigned kind_tally [4] = '{0, 0, 0, 0};
   logic [ColsW-1:0] cols_set = ColsReset;
   logic [RowsW-1:0] rows_set = RowsReset;

   sextant_dot_canvas_store_top #(
      .MAX_COLS(MaxCols),
      .MAX_ROWS(MaxRows)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_x(req_x),
      .req_y(req_y),
      .req_dot_value(req_dot_value),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_symbol_code(rsp_symbol_code),
      .rsp_out_of_range(rsp_out_of_range)
   );

   sdcs_checker #(
      .MAX_COLS(MaxCols),
      .MAX_ROWS(MaxRows)
   ) checker_i (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_x(req_x),
      .req_y(req_y),
      .req_dot_value(req_dot_value),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_symbol_code(rsp_symbol_code),
      .rsp_out_of_range(rsp_out_of_range),
      .errors(errors),
      .outstanding(outstanding),
      .reads_checked(reads_checked)
   );

   always #HalfPeriod clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("sextant_dot_canvas_store_top: mismatch");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (choke_pending) begin
            choke_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (ChokeCycles) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 30);
      end
   end

   task automatic send(input kind_type k, input int unsigned x, input int unsigned y,
                       input int unsigned dv, input int unsigned code);
      if (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_x <= CoordW'(x);
      req_y <= CoordW'(y);
      req_dot_value <= 1'(dv);
      req_char_code <= CodeW'(code);
      do @(posedge clock); while (req_stall);
      kind_tally[k]++;
      if (k == KIND_CLEAR) begin
         clear_since_drain = 1'b1;
      end
   endtask

   // wait for every read result, then for the store to finish any clear
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (clear_since_drain ? SweepCycles + 64 : 32) @(posedge clock);
      clear_since_drain = 1'b0;
   endtask

   task automatic set_geometry(input logic [CsrDataW-1:0] c, input logic [CsrDataW-1:0] r);
      csr_write <= 1'b1;
      csr_index <= CSR_COLS;
      csr_wdata <= c;
      @(posedge clock);
      csr_index <= CSR_ROWS;
      csr_wdata <= r;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      cols_set = c;
      rows_set = r[RowsW-1:0];
      geometries++;
   endtask

   // values mostly below span, biased to a small corner window and both edges of the bound
   function automatic int unsigned pick_coord(input int unsigned span, input int unsigned cap,
                                              input int unsigned win);
      int unsigned roll;
      roll = $urandom_range(99);
      if (span == 0 || roll < 8) begin
         return $urandom_range(cap);
      end
      if (roll < 14) begin
         return span - 1;
      end
      if (roll < 18 && span <= cap) begin
         return span;
      end
      if (roll < 60) begin
         return $urandom_range(((span < win) ? span : win) - 1);
      end
      return $urandom_range(span - 1);
   endfunction

   function automatic int unsigned pick_char_code();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 30) begin
         return 0;
      end else if (roll < 75) begin
         return $urandom_range(126, 32);
      end else if (roll < 90) begin
         return $urandom_range(21'h10FFFF);
      end
      return $urandom & 21'h1FFFFF;
   endfunction

   task automatic random_items(input int count);
      int unsigned ec;
      int unsigned er;
      int unsigned roll;
      for (int n = 0; n < count; n++) begin
         ec = (cols_set > MaxCols) ? MaxCols : cols_set;
         er = (rows_set > MaxRows) ? MaxRows : rows_set;
         roll = $urandom_range(999);
         if (roll < 6 && clears_left > 0) begin
            clears_left--;
            send(KIND_CLEAR, $urandom_range(255), $urandom_range(191),
                 $urandom_range(1), $urandom);
         end else if (roll < 456) begin
            send(KIND_DOT, pick_coord(2 * ec, 255, 8), pick_coord(3 * er, 191, 9),
                 32'($urandom_range(99) < 70), $urandom);
         end else if (roll < 576) begin
            send(KIND_CHAR, pick_coord(ec, 255, 4), pick_coord(er, 191, 3),
                 $urandom_range(1), pick_char_code());
         end else begin
            send(KIND_READ, pick_coord(ec, 255, 4), pick_coord(er, 191, 3),
                 $urandom_range(1), $urandom);
         end
      end
   endtask

   task automatic directed_items();
      send(KIND_READ, 0, 0, 0, 0);
      for (int y = 0; y < 3; y++) begin
         send(KIND_DOT, 0, y, 1, 0);
      end
      send(KIND_READ, 0, 0, 0, 0);
      for (int y = 0; y < 3; y++) begin
         send(KIND_DOT, 1, y, 1, 0);
      end
      send(KIND_READ, 0, 0, 0, 0);
      for (int y = 0; y < 3; y++) begin
         send(KIND_DOT, 0, y, 0, 0);
      end
      send(KIND_READ, 0, 0, 0, 0);
      send(KIND_CHAR, 0, 0, 0, 21'h1FFFFF);
      send(KIND_READ, 0, 0, 0, 0);
      send(KIND_DOT, 255, 191, 1, 0);
      send(KIND_READ, 127, 63, 0, 0);
      send(KIND_DOT, 0, 192, 1, 0);
      send(KIND_READ, 0, 64, 0, 0);
      send(KIND_READ, 128, 0, 0, 0);
      send(KIND_READ, 255, 255, 1, 21'h1FFFFF);
      send(KIND_CLEAR, 0, 0, 0, 0);
      send(KIND_READ, 0, 0, 0, 0);
      send(KIND_READ, 127, 63, 0, 0);
   endtask

   initial begin
      do @(posedge clock); while (reset);
      directed_items();
      random_items(110);
      drain();
      set_geometry(8'd1, 8'd1);
      random_items(100);
      drain();
      set_geometry(8'd0, 8'd7);
      random_items(60);
      drain();
      set_geometry(8'd255, 8'hFF);
      random_items(110);
      drain();
      calm = 1'b1;
      set_geometry(CsrDataW'($urandom_range(128, 1)), CsrDataW'($urandom_range(64, 1)));
      random_items(110);
      drain();
      calm = 1'b0;
      set_geometry(8'd3, 8'd2);
      choke_pending = 1'b1;
      random_items(120);
      drain();
      set_geometry(8'd128, 8'd0);
      random_items(50);
      drain();
      set_geometry(CsrDataW'($urandom_range(255)), CsrDataW'($urandom_range(255)));
      random_items(110);
      drain();
      set_geometry(8'd128, 8'd64);
      random_items(90);
      drain();
      $display("sent %0d dot, %0d char, %0d clear and %0d read items over %0d geometries",
               kind_tally[KIND_DOT], kind_tally[KIND_CHAR], kind_tally[KIND_CLEAR],
               kind_tally[KIND_READ], geometries);
      $display("compared %0d read results, %0d failures", reads_checked, errors);
      if (errors == 0) begin
         $display("sextant_dot_canvas_store_top: match");
      end else begin
         $display("sextant_dot_canvas_store_top: mismatch");
      end
      $finish;
   end

endmodule
